FILE: rtl/core/blop_pkg.sv
`timescale 1ns / 1ps
// Package for the binomial lattice option pricer.
// Holds sizes, register addresses and the sequencer state type; no dependencies.
package blop_pkg;
    localparam int MAX_STEPS = 1024;
    localparam int NODE_AW   = $clog2(MAX_STEPS + 1);
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W    = 5;

    localparam logic [ADDR_W-1:0] ADDR_DOWN    = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_RATIO   = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_INVD    = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_PROB    = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_DISC    = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_STRIKE  = 5'd20;
    localparam logic [ADDR_W-1:0] ADDR_STEPS   = 5'd24;
    localparam logic [ADDR_W-1:0] ADDR_KIND    = 5'd28;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DPOW,
        ST_SPOT,
        ST_TERM,
        ST_RD,
        ST_WAIT,
        ST_MIX,
        ST_DISC,
        ST_INVD,
        ST_WR,
        ST_DONE
    } state_t;
endpackage

FILE: rtl/core/binomial_lattice_option_pricer.sv
`timescale 1ns / 1ps
// Top level of the binomial lattice option pricer: APB registers, stream ports,
// sequencer, node memories and one shared Q2.30 multiplier. Depends on blop_pkg.
//
// One spot price yields one option value. A request first multiplies by d to
// form d^n, then forms the terminal prices and payoffs. Each lattice node then
// takes one memory read, wait, mix, discount, the 1/d step in the American
// modes, and a write-back. The single shared multiplier serialises this
// work. s_tready is low while a request is in flight; the result stays on
// m_tdata until taken.
module binomial_lattice_option_pricer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [blop_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] spot_price
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] root value
    output logic        m_tuser    // [0] saturated
);
    import blop_pkg::*;

    logic [30:0] down_reg;
    logic [31:0] ratio_reg, invd_reg, strike_reg;
    logic [16:0] prob_reg;
    logic [30:0] disc_reg;
    logic [10:0] steps_reg;
    logic [1:0]  kind_reg;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] n_reg, cnt_reg, level_reg, j_reg;
    logic [STEP_W-1:0] n_eff;
    logic [31:0] acc_reg, plo_reg, held_reg, spot_reg;
    logic        sat_reg, outv_reg;
    logic [31:0] out_reg;

    logic [31:0] vmem [0:MAX_STEPS];
    logic [31:0] pmem [0:MAX_STEPS];
    logic [31:0] vrd0_reg, vrd1_reg, prd_reg;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = sat_reg;
    assign n_eff    = (steps_reg > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : steps_reg;

    wire is_put   = kind_reg[0];
    wire american = kind_reg[1];
    wire wr_en    = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg <= 31'h4000_0000; ratio_reg <= 32'h4000_0000;
            invd_reg <= 32'h4000_0000; prob_reg <= 17'd32768;
            disc_reg <= 31'h4000_0000; strike_reg <= '0;
            steps_reg <= 11'd1; kind_reg <= '0;
        end else if (wr_en) begin
            case (paddr)
                ADDR_DOWN:   down_reg   <= pwdata[30:0];
                ADDR_RATIO:  ratio_reg  <= pwdata;
                ADDR_INVD:   invd_reg   <= pwdata;
                ADDR_PROB:   prob_reg   <= pwdata[16:0];
                ADDR_DISC:   disc_reg   <= pwdata[30:0];
                ADDR_STRIKE: strike_reg <= pwdata;
                ADDR_STEPS:  steps_reg  <= pwdata[10:0];
                ADDR_KIND:   kind_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_DOWN:   prdata = {1'b0, down_reg};
            ADDR_RATIO:  prdata = ratio_reg;
            ADDR_INVD:   prdata = invd_reg;
            ADDR_PROB:   prdata = {15'd0, prob_reg};
            ADDR_DISC:   prdata = {1'b0, disc_reg};
            ADDR_STRIKE: prdata = strike_reg;
            ADDR_STEPS:  prdata = {21'd0, steps_reg};
            ADDR_KIND:   prdata = {30'd0, kind_reg};
            default:     prdata = '0;
        endcase
    end

    // shared multiplier operand select
    logic [31:0] mul_a, mul_b, mul_q;
    logic [63:0] prod;
    logic        mul_ovf;
    always_comb begin
        mul_a = acc_reg;
        mul_b = {1'b0, down_reg};
        case (state_reg)
            ST_DPOW: begin mul_a = acc_reg; mul_b = {1'b0, down_reg}; end
            ST_SPOT: begin mul_a = spot_reg; mul_b = acc_reg; end
            ST_TERM: begin mul_a = acc_reg; mul_b = ratio_reg; end
            ST_DISC: begin mul_a = acc_reg; mul_b = {1'b0, disc_reg}; end
            ST_INVD: begin mul_a = prd_reg; mul_b = invd_reg; end
            default: ;
        endcase
        prod    = {32'd0, mul_a} * {32'd0, mul_b} + 64'h2000_0000;
        mul_ovf = |prod[63:62];
        mul_q   = mul_ovf ? 32'hFFFF_FFFF : prod[61:30];
    end

    function automatic logic [31:0] pay(input logic [31:0] s, input logic [31:0] k,
                                        input logic put);
        logic [31:0] r;
        if (put) r = (k > s) ? k - s : 32'd0;
        else     r = (s > k) ? s - k : 32'd0;
        return r;
    endfunction

    logic [16:0] p_eff, q_eff;
    logic [49:0] mix;
    always_comb begin
        p_eff = (prob_reg > 17'd65536) ? 17'd65536 : prob_reg;
        q_eff = 17'd65536 - p_eff;
        mix = {1'b0, 17'd0, vrd1_reg} * {33'd0, p_eff}
            + {1'b0, 17'd0, vrd0_reg} * {33'd0, q_eff} + 50'd32768;
    end

    // node memory access
    logic              pwe, vwe;
    logic [NODE_AW-1:0] waddr, raddr;
    logic [31:0]       pwd, vwd;
    always_comb begin
        pwe = 1'b0; vwe = 1'b0;
        waddr = cnt_reg; raddr = j_reg;
        pwd = mul_q; vwd = pay(mul_q, strike_reg, is_put);
        case (state_reg)
            ST_SPOT, ST_TERM: begin pwe = 1'b1; vwe = 1'b1; waddr = cnt_reg; end
            ST_WR: begin
                vwe = 1'b1; waddr = j_reg; vwd = held_reg;
                pwe = american; pwd = plo_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pwe) pmem[waddr] <= pwd;
        if (vwe) vmem[waddr] <= vwd;
        prd_reg  <= pmem[raddr];
        vrd0_reg <= vmem[raddr];
    end
    always_ff @(posedge aclk) begin
        vrd1_reg <= vmem[raddr + NODE_AW'(1)];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready)
                         state_next = (n_eff == '0) ? ST_SPOT : ST_DPOW;
            ST_DPOW: if (cnt_reg == n_reg - STEP_W'(1)) state_next = ST_SPOT;
            ST_SPOT: state_next = (n_reg == '0) ? ST_DONE : ST_TERM;
            ST_TERM: if (cnt_reg == n_reg) state_next = ST_RD;
            ST_RD:   state_next = ST_WAIT;
            ST_WAIT: state_next = ST_MIX;
            ST_MIX:  state_next = ST_DISC;
            ST_DISC: state_next = american ? ST_INVD : ST_WR;
            ST_INVD: state_next = ST_WR;
            ST_WR: begin
                if (j_reg == level_reg - STEP_W'(1) && level_reg == STEP_W'(1))
                    state_next = ST_DONE;
                else state_next = ST_RD;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            outv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (outv_reg && m_tready) outv_reg <= 1'b0;
            if (state_reg == ST_DONE) outv_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    n_reg    <= n_eff;
                    spot_reg <= s_tdata;
                    acc_reg  <= 32'h4000_0000;
                    cnt_reg  <= '0;
                    sat_reg  <= 1'b0;
                end
            end
            ST_DPOW: begin
                acc_reg <= mul_q; sat_reg <= sat_reg | mul_ovf;
                cnt_reg <= (cnt_reg == n_reg - STEP_W'(1)) ? '0 : cnt_reg + STEP_W'(1);
            end
            ST_SPOT, ST_TERM: begin
                acc_reg <= mul_q; sat_reg <= sat_reg | mul_ovf;
                cnt_reg <= cnt_reg + STEP_W'(1);
                level_reg <= n_reg; j_reg <= '0;
                out_reg <= pay(mul_q, strike_reg, is_put);
            end
            ST_MIX:  acc_reg <= mix[47:16];
            ST_DISC: begin held_reg <= mul_q; sat_reg <= sat_reg | mul_ovf; end
            ST_INVD: begin
                plo_reg <= mul_q; sat_reg <= sat_reg | mul_ovf;
                if (pay(mul_q, strike_reg, is_put) > held_reg)
                    held_reg <= pay(mul_q, strike_reg, is_put);
            end
            ST_WR: begin
                if (j_reg == '0) out_reg <= held_reg;
                if (j_reg == level_reg - STEP_W'(1)) begin
                    j_reg <= '0; level_reg <= level_reg - STEP_W'(1);
                end else j_reg <= j_reg + STEP_W'(1);
            end
            default: ;
        endcase
    end
endmodule
